/* rtl/core/csmv_pkg.sv */
// shared types and constants of the coo sparse matrix-vector block
package csmv_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 10;
    localparam int LEN_W  = 11;
    localparam int DATA_W = 32;
    localparam int SUM_W  = 48;
    localparam int PROD_W = 2 * DATA_W;
    localparam int FRAC_W = 16;

    localparam logic [LEN_W-1:0] VL_RESET = 11'd1024;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // depths of the job queue and the result queue
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ACCUM   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    // operations handed from the front to the back
    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // one classified job in the queue
    typedef struct packed {
        t_op                        op;
        logic [IDX_W-1:0]           row;
        logic signed [DATA_W-1:0]   a;
        logic signed [DATA_W-1:0]   b;
        logic                       zero;
        logic                       size_err;
        logic                       idx_err;
    } t_job;

    // one result item
    typedef struct packed {
        logic signed [SUM_W-1:0]    row_sum;
        logic                       size_err;
        logic                       idx_err;
    } t_result;

endpackage

/* rtl/core/csmv_fifo.sv */
// small register queue used between the parts of the block and toward the receiver
module csmv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CNTW-1:0]  r_count;
    logic [PW-1:0]    n_wptr;
    logic [PW-1:0]    n_rptr;
    logic [CNTW-1:0]  n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointer wrap and occupancy
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* rtl/core/csmv_front.sv */
// front part: takes items, keeps the dense vector and load count, classifies jobs
module csmv_front import csmv_pkg::*; #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [LEN_W-1:0]            i_cfg_data,
    input  logic                        i_accept,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic [IDX_W-1:0]            i_row_index,
    input  logic [IDX_W-1:0]            i_col_index,
    input  logic signed [DATA_W-1:0]    i_value,
    output logic                        o_job_valid,
    output t_job                        o_job,
    input  logic                        i_job_full
);

    localparam int AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LCW = $clog2(MAX_LENGTH + 2);
    localparam int CW  = (LCW > LEN_W) ? LCW : LEN_W;
    localparam int IW  = (AW > IDX_W) ? AW : IDX_W;

    logic                       r_vld;
    logic [LCW-1:0]             r_load_count;
    logic                       r_flag;
    logic [LEN_W-1:0]           r_vector_length;
    t_op                        r_op;
    logic [IDX_W-1:0]           r_row;
    logic signed [DATA_W-1:0]   r_a;
    logic signed [DATA_W-1:0]   r_dense;
    logic                       r_zero;
    logic                       r_size_err;
    logic                       r_idx_err;
    logic signed [DATA_W-1:0]   r_dense_mem [MAX_LENGTH];

    logic                       n_vld;
    logic [LCW-1:0]             n_load_count;
    logic                       n_flag;
    t_op                        n_op;

    logic [CW-1:0]              w_lc_ext;
    logic [CW-1:0]              w_col_ext;
    logic [CW-1:0]              w_row_ext;
    logic [CW-1:0]              w_vl_ext;
    logic [CW-1:0]              w_max;
    logic [IW-1:0]              w_col_wide;
    logic [AW-1:0]              w_col_addr;
    logic                       w_col_ok;
    logic                       w_row_ok;
    logic                       w_size_ok;
    logic                       w_store;

    // range checks against the current load count and length
    assign w_lc_ext   = CW'(r_load_count);
    assign w_col_ext  = CW'(i_col_index);
    assign w_row_ext  = CW'(i_row_index);
    assign w_vl_ext   = CW'(r_vector_length);
    assign w_max      = CW'(MAX_LENGTH);
    assign w_col_wide = IW'(i_col_index);
    assign w_col_addr = w_col_wide[AW-1:0];
    assign w_col_ok   = (w_col_ext < w_lc_ext) && (w_col_ext < w_max);
    assign w_row_ok   = (w_row_ext < w_vl_ext) && (w_row_ext < w_max);
    assign w_size_ok  = (w_vl_ext <= w_max) && (w_lc_ext == w_vl_ext);
    assign w_store    = i_accept && (t_cmd'(i_cmd) == CMD_LOAD) && (w_lc_ext < w_max);

    // command decode
    always_comb begin
        n_vld        = r_vld && i_job_full;
        n_load_count = r_load_count;
        n_flag       = r_flag;
        n_op         = OP_ACC;
        if (i_accept) begin
            unique case (t_cmd'(i_cmd))
                CMD_LOAD: begin
                    n_vld = 1'b0;
                    if (w_lc_ext < CW'(MAX_LENGTH + 1)) begin
                        n_load_count = r_load_count + 1'b1;
                    end
                end
                CMD_ACCUM: begin
                    n_op  = OP_ACC;
                    n_vld = w_col_ok && w_row_ok;
                    if (!(w_col_ok && w_row_ok)) begin
                        n_flag = 1'b1;
                    end
                end
                CMD_READ: begin
                    n_op  = OP_READ;
                    n_vld = 1'b1;
                end
                CMD_RESTART: begin
                    n_op         = OP_CLEAR;
                    n_vld        = 1'b1;
                    n_load_count = '0;
                    n_flag       = 1'b0;
                end
            endcase
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld           <= 1'b0;
            r_load_count    <= '0;
            r_flag          <= 1'b0;
            r_vector_length <= VL_RESET;
        end else begin
            r_vld        <= n_vld;
            r_load_count <= n_load_count;
            r_flag       <= n_flag;
            if (i_cfg_valid) begin
                r_vector_length <= i_cfg_data;
            end
        end
    end

    // job payload, taken with the flags as they stand before this item
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op       <= n_op;
            r_row      <= i_row_index;
            r_a        <= i_value;
            r_zero     <= !(w_size_ok && w_row_ok);
            r_size_err <= !w_size_ok;
            r_idx_err  <= r_flag;
        end
    end

    // dense vector store with registered read
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_dense_mem[r_load_count[AW-1:0]] <= i_value;
        end
        if (i_accept) begin
            r_dense <= r_dense_mem[w_col_addr];
        end
    end

    // job toward the queue
    assign o_job_valid = r_vld;
    always_comb begin
        o_job          = '0;
        o_job.op       = r_op;
        o_job.row      = r_row;
        o_job.a        = r_a;
        o_job.b        = r_dense;
        o_job.zero     = r_zero;
        o_job.size_err = r_size_err;
        o_job.idx_err  = r_idx_err;
    end

endmodule

/* rtl/core/csmv_back.sv */
// back part: row accumulators, multiply-accumulate pipeline and clearing sweep
module csmv_back import csmv_pkg::*; #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_job                                i_job,
    input  logic                                i_job_empty,
    output logic                                o_job_pop,
    output logic                                o_res_push,
    output t_result                             o_res,
    input  logic [$clog2(RES_DEPTH+1)-1:0]      i_res_count,
    output logic                                o_init_busy
);

    localparam int AW     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int IW     = (AW > IDX_W) ? AW : IDX_W;
    localparam int RES_CW = $clog2(RES_DEPTH + 1);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    t_state                     r_state;
    logic [AW-1:0]              r_clr_addr;
    logic                       r_init;
    logic                       r_b_vld;
    t_op                        r_b_op;
    logic [AW-1:0]              r_b_row;
    logic                       r_b_zero;
    logic                       r_b_size_err;
    logic                       r_b_idx_err;
    logic                       r_b_fwd;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SUM_W-1:0]    r_accr;
    logic signed [SUM_W-1:0]    r_wsum;
    logic signed [SUM_W-1:0]    r_acc_mem [MAX_LENGTH];

    logic [IW-1:0]              w_row_wide;
    logic [AW-1:0]              w_a_row;
    logic                       w_b_read;
    logic                       w_b_acc;
    logic [RES_CW-1:0]          w_pending;
    logic                       w_room;
    logic                       w_pop;
    logic                       w_fwd;
    logic signed [SUM_W-1:0]    w_base;
    logic signed [SUM_W-1:0]    w_add;
    logic [SUM_W:0]             w_sum;
    logic signed [SUM_W-1:0]    w_sat;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic signed [SUM_W-1:0]    w_wdata;

    // stage a: take a job when the pipeline and result queue allow
    assign w_row_wide = IW'(i_job.row);
    assign w_a_row    = w_row_wide[AW-1:0];
    assign w_b_read   = r_b_vld && (r_b_op == OP_READ);
    assign w_b_acc    = r_b_vld && (r_b_op == OP_ACC);
    assign w_pending  = RES_CW'(i_res_count) + RES_CW'(w_b_read);
    assign w_room     = w_pending < RES_CW'(RES_DEPTH);
    assign w_pop      = (r_state == ST_RUN) && !i_job_empty
                        && ((i_job.op != OP_READ) || w_room);
    assign w_fwd      = w_b_acc && (r_b_row == w_a_row);
    assign o_job_pop  = w_pop;
    assign o_init_busy = r_init;

    // stage b: floor of product to q32.16, saturating add
    assign w_base = r_b_fwd ? r_wsum : r_accr;
    assign w_add  = r_prod[FRAC_W +: SUM_W];
    assign w_sum  = {w_base[SUM_W-1], w_base} + {w_add[SUM_W-1], w_add};
    always_comb begin
        if (w_sum[SUM_W] != w_sum[SUM_W-1]) begin
            w_sat = w_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sat = w_sum[SUM_W-1:0];
        end
    end

    // result of a read
    assign o_res_push       = w_b_read;
    assign o_res.row_sum    = r_b_zero ? '0 : w_base;
    assign o_res.size_err   = r_b_size_err;
    assign o_res.idx_err    = r_b_idx_err;

    // accumulator write port: sweep or stage b update
    assign w_we    = (r_state == ST_CLEAR) || w_b_acc;
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_b_row;
    assign w_wdata = (r_state == ST_CLEAR) ? '0 : w_sat;

    // state, sweep counter and stage b registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_init     <= 1'b1;
            r_b_vld    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(MAX_LENGTH - 1)) begin
                        r_state <= ST_RUN;
                        r_init  <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (w_pop && (i_job.op == OP_CLEAR)) begin
                        r_state    <= ST_CLEAR;
                        r_clr_addr <= '0;
                    end
                end
            endcase
            r_b_vld <= w_pop && ((i_job.op == OP_ACC) || (i_job.op == OP_READ));
        end
    end

    // stage b payload
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_b_op       <= i_job.op;
            r_b_row      <= w_a_row;
            r_b_zero     <= i_job.zero;
            r_b_size_err <= i_job.size_err;
            r_b_idx_err  <= i_job.idx_err;
            r_b_fwd      <= w_fwd;
            r_prod       <= $signed(i_job.a) * $signed(i_job.b);
        end
        if (w_b_acc) begin
            r_wsum <= w_sat;
        end
    end

    // accumulator memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_acc_mem[w_waddr] <= w_wdata;
        end
        if (w_pop) begin
            r_accr <= r_acc_mem[w_a_row];
        end
    end

endmodule

/* rtl/core/coo_sparse_matvec.sv */
// Sparse matrix times dense vector in coordinate form, signed Q16.16 fixed point.
//
// Input items arrive on a queue-style port: an item is taken at a clock edge
// with push high and full low. Commands: load the next dense element, add
// value times a dense element into a row, read a row sum, restart.
// Results (row reads only) leave on a queue-style port: the oldest result sits
// on o_row_sum / o_size_error / o_index_error while empty is low and is taken
// at an edge with pop high. vector_length is written on the cfg channel.
// Throughput is one item per cycle outside a clearing sweep and while results
// are drained: the back does one multiply-accumulate per cycle on a
// single-write, single-read accumulator memory, with a bypass for back-to-back
// updates of one row. A row read passes the front job register, the job queue
// and the stage b register into the result queue before it shows on the result
// port. A restart makes the back zero the accumulators one row per cycle;
// items keep entering the job queue meanwhile. After reset the same sweep runs
// with full held high. When the receiver stalls, results wait in a four-deep
// result queue, then the back holds reads and the job queue fills until full rises.
module coo_sparse_matvec import csmv_pkg::*; #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [LEN_W-1:0]            i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic [IDX_W-1:0]            i_row_index,
    input  logic [IDX_W-1:0]            i_col_index,
    input  logic signed [DATA_W-1:0]    i_value,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [SUM_W-1:0]     o_row_sum,
    output logic                        o_size_error,
    output logic                        o_index_error
);

    localparam int JOB_W  = $bits(t_job);
    localparam int RES_W  = $bits(t_result);
    localparam int JOB_CW = $clog2(JOB_DEPTH + 1);
    localparam int RES_CW = $clog2(RES_DEPTH + 1);

    logic                   w_accept;
    logic                   w_job_valid;
    t_job                   w_job_in;
    logic                   w_job_full;
    t_job                   w_job_out;
    logic                   w_job_empty;
    logic                   w_job_pop;
    logic [JOB_CW-1:0]      w_job_count;
    logic                   w_res_push;
    t_result                w_res_in;
    t_result                w_res_out;
    logic                   w_res_full;
    logic [RES_CW-1:0]      w_res_count;
    logic                   w_init_busy;

    // input handshake
    assign o_cfg_ready = 1'b1;
    assign full        = w_init_busy || (w_job_valid && w_job_full);
    assign w_accept    = push && !full;

    csmv_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_cmd       (i_cmd),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value     (i_value),
        .o_job_valid (w_job_valid),
        .o_job       (w_job_in),
        .i_job_full  (w_job_full)
    );

    // queue between front and back
    csmv_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty),
        .o_count (w_job_count)
    );

    csmv_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_job_empty (w_job_empty || (w_job_count == '0)),
        .o_job_pop   (w_job_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .i_res_count (w_res_count),
        .o_init_busy (w_init_busy)
    );

    // result queue toward the receiver
    csmv_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push && !w_res_full),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty),
        .o_count (w_res_count)
    );

    assign o_row_sum     = w_res_out.row_sum;
    assign o_size_error  = w_res_out.size_err;
    assign o_index_error = w_res_out.idx_err;

endmodule

/* rtl/core/csmv_checker.sv */
// port-level checks of the coo sparse matrix-vector block, bound to the top level
module csmv_checker import csmv_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        full,
    input  logic                        empty,
    input  logic                        pop,
    input  logic signed [SUM_W-1:0]     o_row_sum,
    input  logic                        o_size_error,
    input  logic                        o_index_error
);

    // a size error always comes with a zero sum
    a_size_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_size_error) |-> (o_row_sum == '0))
        else $error("row sum not zero on size error");

    // a waiting result is not lost or changed while the receiver stalls
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_row_sum)
                              && $stable(o_size_error) && $stable(o_index_error)))
        else $error("waiting result changed while stalled");

    // when reset is released, the clearing sweep blocks input and shows no result
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (full && empty))
        else $error("input open or result shown during reset sweep");

endmodule

bind coo_sparse_matvec csmv_checker u_csmv_checker (.*);
